@@ hdl/md5_pkg.sv @@
// Shared types, constants and step tables for the MD5 digest block.
// No dependencies; used by md5_step, md5_blkbuf and md5_message_digest_top.
package md5_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned FillW      = $clog2(BlockBytes);
  localparam int unsigned WordsPerBlk = BlockBytes / 4;
  localparam int unsigned WordIdxW   = $clog2(WordsPerBlk);
  localparam int unsigned LenPos     = 56;

  localparam logic [7:0]  PadMarker = 8'h80;

  localparam logic [31:0] ChainInitA = 32'h67452301;
  localparam logic [31:0] ChainInitB = 32'hefcdab89;
  localparam logic [31:0] ChainInitC = 32'h98badcfe;
  localparam logic [31:0] ChainInitD = 32'h10325476;

  localparam logic [31:0] RoundConst [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] RotAmount [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  typedef enum logic [2:0] {
    StIdle,
    StPad,
    StCompPre,
    StComp,
    StFold,
    StOut0,
    StOut1
  } state_e;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } work_t;

  typedef struct packed {
    logic             en;
    logic [FillW-1:0] addr;
    logic [7:0]       data;
  } buf_wr_t;

  // Message word used by a given step.
  function automatic logic [WordIdxW-1:0] msg_index(input logic [5:0] step);
    logic [3:0] lo;
    logic [3:0] idx;
    lo = step[3:0];
    case (step[5:4])
      2'd0:    idx = lo;
      2'd1:    idx = 4'((lo * 4'd5) + 4'd1);
      2'd2:    idx = 4'((lo * 4'd3) + 4'd5);
      default: idx = 4'(lo * 4'd7);
    endcase
    return idx;
  endfunction

  function automatic logic [31:0] bswap32(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

@@ hdl/md5_step.sv @@
// One MD5 compression step: round function, adds and rotate.
// Depends on md5_pkg for the constant tables and the work word type.
module md5_step (
  input  md5_pkg::work_t work_i,
  input  logic [5:0]     step_i,
  input  logic [31:0]    msg_word_i,
  output logic [31:0]    new_b_o
);

  logic [31:0] f;
  logic [31:0] sum;
  logic [4:0]  rot;
  logic [63:0] rot_wide;

  always_comb begin
    case (step_i[5:4])
      2'd0:    f = (work_i.b & work_i.c) | (~work_i.b & work_i.d);
      2'd1:    f = (work_i.b & work_i.d) | (work_i.c & ~work_i.d);
      2'd2:    f = work_i.b ^ work_i.c ^ work_i.d;
      default: f = work_i.c ^ (work_i.b | ~work_i.d);
    endcase
  end

  assign sum      = work_i.a + f + md5_pkg::RoundConst[step_i] + msg_word_i;
  assign rot      = md5_pkg::RotAmount[{step_i[5:4], step_i[1:0]}];
  assign rot_wide = {sum, sum} << rot;
  assign new_b_o  = work_i.b + rot_wide[63:32];

endmodule

@@ hdl/md5_blkbuf.sv @@
// Block buffer: 64 bytes written one byte a beat, read one 32-bit word a cycle.
// Depends on md5_pkg for widths and the write port struct.
module md5_blkbuf (
  input  logic                              clk_i,
  input  md5_pkg::buf_wr_t                  wr_i,
  input  logic [md5_pkg::WordIdxW-1:0]      rd_addr_i,
  output logic [31:0]                       rd_data_o
);

  logic [3:0][7:0] mem_q [md5_pkg::WordsPerBlk];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr[md5_pkg::FillW-1:2]][wr_i.addr[1:0]] <= wr_i.data;
    end
  end

  // Bytes are little-endian within a word.
  always_ff @(posedge clk_i) begin
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

@@ hdl/md5_message_digest_top.sv @@
// MD5 digest block: byte stream in, two 64-bit digest beats out.
// Depends on md5_pkg, md5_blkbuf and md5_step.
//
// Message bytes arrive one per beat on the slave stream; tuser flags a beat
// that carries a byte and tlast marks the final beat of a message (it may
// carry a byte or be empty). Bytes are taken one per cycle until a 64-byte
// block is full; the block then runs through the shared step unit, one MD5
// step per cycle, and holds the input off while it fetches the first word,
// runs the 64 steps and folds the result into the chaining words; no new
// bytes are taken while a block is compressed. After the final beat the
// padding bytes are written one per cycle (up to 64 of them, up to 72
// when the tail is 56 bytes or longer and a second block is needed), the
// last blocks are compressed, and the digest goes out as two master beats:
// tuser 0 carries digest bytes 0-7, tuser 1 with tlast carries bytes 8-15,
// the first byte in bits 63:56. The block then starts a new message.
// Input is not accepted from the final beat until the second digest beat
// is taken.
module md5_message_digest_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream: message bytes
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] msg_byte
  input  logic        s_axis_tuser_i,   // [0] byte_valid
  input  logic        s_axis_tlast_i,   // end_of_message
  // master stream: digest halves
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [63:0] digest_half
  output logic        m_axis_tuser_o,   // [0] half_index
  output logic        m_axis_tlast_o    // digest_last
);

  localparam logic [md5_pkg::FillW-1:0] FillLast =
    md5_pkg::FillW'(md5_pkg::BlockBytes - 1);
  localparam logic [md5_pkg::FillW-1:0] FillLenPos =
    md5_pkg::FillW'(md5_pkg::LenPos);

  md5_pkg::state_e state_q, state_d;

  logic [md5_pkg::FillW-1:0] fill_q;
  logic [63:0]               total_bits_q;
  logic [5:0]                step_q;
  logic                      pad_mode_q;   // final beat seen, padding under way
  logic                      sent80_q;     // pad marker already written
  logic                      len_ok_q;     // current block takes the length

  logic [31:0]    chain_a_q, chain_b_q, chain_c_q, chain_d_q;
  md5_pkg::work_t work_q;

  logic                          in_beat;
  logic                          out_beat;
  md5_pkg::buf_wr_t              buf_wr;
  logic [md5_pkg::WordIdxW-1:0]  rd_addr;
  logic [31:0]                   msg_word;
  logic [31:0]                   new_b;
  logic [7:0]                    pad_byte;

  assign in_beat  = s_axis_tvalid_i & s_axis_tready_o;
  assign out_beat = m_axis_tvalid_o & m_axis_tready_i;

  // Padding byte: marker first, then zeros, then the length in the final block.
  always_comb begin
    if (!sent80_q) begin
      pad_byte = md5_pkg::PadMarker;
    end else if (len_ok_q && (fill_q >= FillLenPos)) begin
      pad_byte = total_bits_q[{fill_q[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      md5_pkg::StIdle: begin
        if (in_beat) begin
          if (s_axis_tuser_i && (fill_q == FillLast)) begin
            state_d = md5_pkg::StCompPre;
          end else if (s_axis_tlast_i) begin
            state_d = md5_pkg::StPad;
          end
        end
      end
      md5_pkg::StPad: begin
        if (fill_q == FillLast) begin
          state_d = md5_pkg::StCompPre;
        end
      end
      md5_pkg::StCompPre: state_d = md5_pkg::StComp;
      md5_pkg::StComp: begin
        if (step_q == 6'd63) begin
          state_d = md5_pkg::StFold;
        end
      end
      md5_pkg::StFold: begin
        if (!pad_mode_q) begin
          state_d = md5_pkg::StIdle;
        end else if (len_ok_q) begin
          state_d = md5_pkg::StOut0;
        end else begin
          state_d = md5_pkg::StPad;
        end
      end
      md5_pkg::StOut0: begin
        if (m_axis_tready_i) begin
          state_d = md5_pkg::StOut1;
        end
      end
      md5_pkg::StOut1: begin
        if (m_axis_tready_i) begin
          state_d = md5_pkg::StIdle;
        end
      end
      default: state_d = md5_pkg::StIdle;
    endcase
  end

  // Handshake and buffer port controls.
  always_comb begin
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;
    m_axis_tuser_o  = 1'b0;
    m_axis_tlast_o  = 1'b0;
    buf_wr.en       = 1'b0;
    buf_wr.addr     = fill_q;
    buf_wr.data     = s_axis_tdata_i;
    rd_addr         = md5_pkg::msg_index(6'(step_q + 6'd1));
    unique case (state_q)
      md5_pkg::StIdle: begin
        s_axis_tready_o = 1'b1;
        buf_wr.en       = s_axis_tvalid_i & s_axis_tuser_i;
      end
      md5_pkg::StPad: begin
        buf_wr.en   = 1'b1;
        buf_wr.data = pad_byte;
      end
      md5_pkg::StCompPre: rd_addr = md5_pkg::msg_index(6'd0);
      md5_pkg::StComp: ;
      md5_pkg::StFold: ;
      md5_pkg::StOut0: m_axis_tvalid_o = 1'b1;
      md5_pkg::StOut1: begin
        m_axis_tvalid_o = 1'b1;
        m_axis_tuser_o  = 1'b1;
        m_axis_tlast_o  = 1'b1;
      end
      default: ;
    endcase
  end

  // Digest bytes are the chaining words in little-endian byte order.
  assign m_axis_tdata_o = (state_q == md5_pkg::StOut1)
    ? {md5_pkg::bswap32(chain_c_q), md5_pkg::bswap32(chain_d_q)}
    : {md5_pkg::bswap32(chain_a_q), md5_pkg::bswap32(chain_b_q)};

  md5_blkbuf u_blkbuf (
    .clk_i     (clk_i),
    .wr_i      (buf_wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (msg_word)
  );

  md5_step u_step (
    .work_i     (work_q),
    .step_i     (step_q),
    .msg_word_i (msg_word),
    .new_b_o    (new_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= md5_pkg::StIdle;
      fill_q       <= '0;
      total_bits_q <= '0;
      step_q       <= '0;
      pad_mode_q   <= 1'b0;
      sent80_q     <= 1'b0;
      len_ok_q     <= 1'b0;
      chain_a_q    <= md5_pkg::ChainInitA;
      chain_b_q    <= md5_pkg::ChainInitB;
      chain_c_q    <= md5_pkg::ChainInitC;
      chain_d_q    <= md5_pkg::ChainInitD;
      work_q       <= '0;
    end else begin
      state_q <= state_d;

      // Advance the fill pointer on every byte written; it wraps at the block size.
      if (buf_wr.en) begin
        fill_q <= fill_q + md5_pkg::FillW'(1);
      end

      if (in_beat && s_axis_tuser_i) begin
        total_bits_q <= total_bits_q + 64'd8;
      end

      if (in_beat && s_axis_tlast_i) begin
        pad_mode_q <= 1'b1;
      end

      if ((state_q == md5_pkg::StPad) && !sent80_q) begin
        sent80_q <= 1'b1;
        if (fill_q < FillLenPos) begin
          len_ok_q <= 1'b1;
        end
      end

      // Spill block done: the next one carries the length.
      if ((state_q == md5_pkg::StFold) && pad_mode_q && sent80_q) begin
        len_ok_q <= 1'b1;
      end

      if (state_q == md5_pkg::StCompPre) begin
        work_q <= '{a: chain_a_q, b: chain_b_q, c: chain_c_q, d: chain_d_q};
        step_q <= '0;
      end

      if (state_q == md5_pkg::StComp) begin
        work_q <= '{a: work_q.d, b: new_b, c: work_q.b, d: work_q.c};
        step_q <= step_q + 6'd1;
      end

      if (state_q == md5_pkg::StFold) begin
        chain_a_q <= chain_a_q + work_q.a;
        chain_b_q <= chain_b_q + work_q.b;
        chain_c_q <= chain_c_q + work_q.c;
        chain_d_q <= chain_d_q + work_q.d;
      end

      // Second digest beat taken: start a new message.
      if ((state_q == md5_pkg::StOut1) && out_beat) begin
        chain_a_q    <= md5_pkg::ChainInitA;
        chain_b_q    <= md5_pkg::ChainInitB;
        chain_c_q    <= md5_pkg::ChainInitC;
        chain_d_q    <= md5_pkg::ChainInitD;
        total_bits_q <= '0;
        pad_mode_q   <= 1'b0;
        sent80_q     <= 1'b0;
        len_ok_q     <= 1'b0;
      end
    end
  end

endmodule

@@ test/md5_message_digest_top_tb.sv @@
// Self-checking testbench for md5_message_digest_top: byte stream in, digest halves out.
// Depends only on the RTL; it carries its own MD5 predictor and compares every digest beat.
module md5_message_digest_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ResetCycles = 6;
  localparam int unsigned RandItems   = 950;
  localparam int unsigned CalmItems   = 120;   // tail of the run with no idling
  localparam int unsigned HoldCycles  = 400;   // long receiver hold-off
  localparam int unsigned SettleCycles = 300;  // > padding plus two compressions
  localparam int unsigned CycleLimit  = 2000000;
  localparam int unsigned DirRows     = 10;

  localparam logic FirstHalf  = 1'b0;
  localparam logic SecondHalf = 1'b1;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;

  localparam logic [31:0] StepConst [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int unsigned StepShift [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  // One message beat; known/digest carry a hand-typed digest for the row
  // that ends a message, used in place of the predicted one.
  typedef struct packed {
    logic [7:0]   data;
    logic         valid;
    logic         eom;
    logic         known;
    logic [127:0] digest;
  } msg_beat_t;

  typedef struct {
    logic [63:0] half;
    logic        index;
    logic        last;
  } digest_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;
  logic        s_axis_tuser_i;
  logic        s_axis_tlast_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [63:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        m_axis_tlast_o;

  // Predictor state: chaining words, partial block, message length.
  logic [31:0] chain_w [4];
  logic [7:0]  block_bytes [64];
  int unsigned block_fill;
  logic [63:0] msg_bits;

  digest_beat_t pending_digest_q [$];
  int unsigned  mismatch_cnt = 0;
  int unsigned  beats_seen = 0;
  int unsigned  cycle_cnt = 0;
  bit           calm = 1'b0;
  int unsigned  tx_idle_pct = 0;

  // Directed rows: empty message, ignored beats, data on the final beat,
  // an empty final beat after data, back-to-back messages, byte extremes.
  msg_beat_t dir_rows [DirRows] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, 128'hd41d8cd98f00b204e9800998ecf8427e},
    '{8'hff, 1'b0, 1'b0, 1'b0, 128'h0},
    '{8'h61, 1'b1, 1'b0, 1'b0, 128'h0},
    '{8'ha5, 1'b0, 1'b1, 1'b1, 128'h0cc175b9c0f1b6a831c399e269772661},
    '{8'h61, 1'b1, 1'b0, 1'b0, 128'h0},
    '{8'h62, 1'b1, 1'b0, 1'b0, 128'h0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 128'h0},
    '{8'h63, 1'b1, 1'b1, 1'b1, 128'h900150983cd24fb0d6963f7d28e17f72},
    '{8'h00, 1'b1, 1'b1, 1'b0, 128'h0},
    '{8'hff, 1'b1, 1'b1, 1'b0, 128'h0}
  };

  md5_message_digest_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // Run the 64 MD5 steps on the buffered block and fold into the chain.
  task automatic md5_compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f;
    int unsigned g, r;
    for (int unsigned i = 0; i < 16; i++) begin
      w[i] = {block_bytes[4*i+3], block_bytes[4*i+2], block_bytes[4*i+1], block_bytes[4*i]};
    end
    a = chain_w[0];
    b = chain_w[1];
    c = chain_w[2];
    d = chain_w[3];
    for (int unsigned s = 0; s < 64; s++) begin
      r = s >> 4;
      case (r)
        0: begin
          f = (b & c) | (~b & d);
          g = s;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * s + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * s + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * s) % 16;
        end
      endcase
      f = a + f + StepConst[s] + w[g];
      a = d;
      d = c;
      c = b;
      b = b + rotl32(f, StepShift[r * 4 + (s % 4)]);
    end
    chain_w[0] += a;
    chain_w[1] += b;
    chain_w[2] += c;
    chain_w[3] += d;
  endtask

  task automatic md5_absorb_byte(input logic [7:0] v);
    block_bytes[block_fill] = v;
    block_fill++;
    if (block_fill == 64) begin
      md5_compress_block();
      block_fill = 0;
    end
  endtask

  task automatic md5_start_message();
    chain_w[0] = InitA;
    chain_w[1] = InitB;
    chain_w[2] = InitC;
    chain_w[3] = InitD;
    block_fill = 0;
    msg_bits = '0;
  endtask

  // Advance the predictor by one accepted beat; queue the digest halves
  // when the beat ends the message.
  task automatic md5_take_beat(input msg_beat_t bt);
    logic [63:0]  len;
    logic [127:0] dig;
    digest_beat_t eb;
    if (bt.valid) begin
      md5_absorb_byte(bt.data);
      msg_bits += 64'd8;
    end
    if (bt.eom) begin
      len = msg_bits;
      md5_absorb_byte(8'h80);
      while (block_fill != 56) md5_absorb_byte(8'h00);
      for (int unsigned i = 0; i < 8; i++) md5_absorb_byte(len[8*i +: 8]);
      // Digest bytes in hex reading order: low byte of word A first.
      dig = '0;
      for (int unsigned i = 0; i < 16; i++) begin
        dig = {dig[119:0], chain_w[i >> 2][8*(i & 3) +: 8]};
      end
      if (bt.known) dig = bt.digest;
      eb.half  = dig[127:64];
      eb.index = FirstHalf;
      eb.last  = 1'b0;
      pending_digest_q.push_back(eb);
      eb.half  = dig[63:0];
      eb.index = SecondHalf;
      eb.last  = 1'b1;
      pending_digest_q.push_back(eb);
      md5_start_message();
    end
  endtask

  // Offer one beat at the falling edge, hold it until accepted, then
  // optionally drop valid for a random burst.
  task automatic send_beat(input msg_beat_t bt);
    int unsigned gap;
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= bt.data;
    s_axis_tuser_i  <= bt.valid;
    s_axis_tlast_i  <= bt.eom;
    do @(posedge clk_i); while (!s_axis_tready_o);
    md5_take_beat(bt);
    if (!calm && $urandom_range(99, 0) < tx_idle_pct) begin
      gap = $urandom_range(12, 1);
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Compare every accepted digest beat with the oldest expectation.
  always @(posedge clk_i) begin
    digest_beat_t eb;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      beats_seen++;
      if (pending_digest_q.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected digest beat, expected none, got %h tuser %b tlast %b",
                 $time, m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
      end else begin
        eb = pending_digest_q.pop_front();
        if (m_axis_tdata_o !== eb.half) begin
          mismatch_cnt++;
          $display("%0t: digest half: expected %h, got %h", $time, eb.half, m_axis_tdata_o);
        end
        if (m_axis_tuser_o !== eb.index) begin
          mismatch_cnt++;
          $display("%0t: half index: expected %b, got %b", $time, eb.index, m_axis_tuser_o);
        end
        if (m_axis_tlast_o !== eb.last) begin
          mismatch_cnt++;
          $display("%0t: digest last: expected %b, got %b", $time, eb.last, m_axis_tlast_o);
        end
      end
    end
  end

  // Receiver: random tready bursts, one long hold-off once the run is under
  // way so the block backs up and stalls its input, no stalls when calm.
  initial begin
    int unsigned burst;
    int unsigned ticks;
    int unsigned rx_idle_pct;
    bit held_off;
    ticks = 0;
    rx_idle_pct = 0;
    held_off = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      ticks++;
      if (ticks % 64 == 0) begin
        case ($urandom_range(2, 0))
          0: rx_idle_pct = 0;
          1: rx_idle_pct = 15;
          default: rx_idle_pct = 40;
        endcase
      end
      if (!calm && !held_off && beats_seen >= 14) begin
        m_axis_tready_i <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
        held_off = 1'b1;
      end else if (!calm && $urandom_range(99, 0) < rx_idle_pct) begin
        burst = $urandom_range(12, 1);
        m_axis_tready_i <= 1'b0;
        repeat (burst - 1) @(negedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if the traffic never drains.
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("md5_message_digest_top: mismatch");
    $finish;
  end

  // Main sequence: reset, directed rows, random messages, drain, verdict.
  initial begin
    int unsigned items_sent;
    int unsigned msg_cnt;
    int unsigned len;
    int unsigned pick;
    bit          carry;
    msg_beat_t   bt;
    items_sent = 0;
    msg_cnt = 0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = 8'h00;
    s_axis_tuser_i  = 1'b0;
    s_axis_tlast_i  = 1'b0;
    m_axis_tready_i = 1'b0;
    md5_start_message();
    for (int unsigned i = 0; i < 64; i++) block_bytes[i] = 8'h00;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int unsigned k = 0; k < DirRows; k++) send_beat(dir_rows[k]);

    // Random messages: mostly short, often right at the padding boundaries,
    // a few spanning several blocks; stray beats without data mixed in.
    while (items_sent < RandItems) begin
      pick = $urandom_range(9, 0);
      if (pick < 4) begin
        len = $urandom_range(20, 0);
      end else if (pick < 6) begin
        case ($urandom_range(9, 0))
          0: len = 55;
          1: len = 56;
          2: len = 57;
          3: len = 63;
          4: len = 64;
          5: len = 65;
          6: len = 119;
          7: len = 120;
          8: len = 127;
          default: len = 128;
        endcase
      end else if (pick < 9) begin
        len = $urandom_range(120, 21);
      end else begin
        len = $urandom_range(200, 121);
      end
      case ($urandom_range(2, 0))
        0: tx_idle_pct = 0;
        1: tx_idle_pct = 10;
        default: tx_idle_pct = 35;
      endcase
      // Once, hold the sender until every pending digest has come out;
      // drop valid first so the last beat is not offered again.
      if (msg_cnt == 8) begin
        @(negedge clk_i);
        s_axis_tvalid_i <= 1'b0;
        while (pending_digest_q.size() != 0) @(posedge clk_i);
      end
      carry = (len > 0) && ($urandom_range(1, 0) == 1);
      for (int unsigned i = 0; i < len; i++) begin
        if ($urandom_range(15, 0) == 0) begin
          bt = '{8'($urandom_range(255, 0)), 1'b0, 1'b0, 1'b0, 128'h0};
          send_beat(bt);
          items_sent++;
        end
        bt = '{8'($urandom_range(255, 0)), 1'b1, carry && (i == len - 1), 1'b0, 128'h0};
        send_beat(bt);
        items_sent++;
      end
      if (!carry) begin
        bt = '{8'($urandom_range(255, 0)), 1'b0, 1'b1, 1'b0, 128'h0};
        send_beat(bt);
        items_sent++;
      end
      msg_cnt++;
      if (items_sent + CalmItems >= RandItems) calm = 1'b1;
    end

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    // Drain, then idle a while longer to catch any stray digest beat.
    while (pending_digest_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("md5_message_digest_top: match");
    end else begin
      $display("md5_message_digest_top: mismatch");
    end
    $finish;
  end

endmodule
